// File: hw/rtl/keypad_code_lock_core_defines.svh
// Assertion macros shared by the keypad code lock RTL.
// Each macro takes a label, a clock, a property expression and a message; KCL_ASSERT also takes a reset.
`ifndef KEYPAD_CODE_LOCK_CORE_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define KCL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KCL_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCL_ASSERT(name, clk, rst, prop, msg)
`define KCL_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: hw/rtl/kcl_pkg.sv
package kcl_pkg;

   localparam int NUM_DIGITS = 4;
   localparam int KEY_W      = 4;
   localparam int ROWS_W     = 4;
   localparam int COUNT_W    = 3;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SECRET_DIGIT_0 = 2'd0,
      CSR_SECRET_DIGIT_1 = 2'd1,
      CSR_SECRET_DIGIT_2 = 2'd2,
      CSR_SECRET_DIGIT_3 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ROWS_W-1:0] rows_col_a;
      logic [ROWS_W-1:0] rows_col_b;
      logic [ROWS_W-1:0] rows_col_c;
   } req_type;

   typedef struct packed {
      logic               key_valid;
      logic [KEY_W-1:0]   key_code;
      logic [COUNT_W-1:0] digit_count;
      logic               entry_done;
      logic               code_ok;
   } rsp_type;

   // Decoded scan passed from the decoder to the entry controller.
   typedef struct packed {
      logic             pressed;
      logic [KEY_W-1:0] key_code;
   } scan_type;

   typedef logic [NUM_DIGITS-1:0][KEY_W-1:0] secret_array_type;

   localparam secret_array_type SECRET_RESET = {4'd4, 4'd3, 4'd2, 4'd1};

   // Keypad position {column, row} to key code; 10 is star, 11 is hash.
   function automatic logic [KEY_W-1:0] key_map(input logic [3:0] pos);
      logic [KEY_W-1:0] code;
      case (pos)
         4'd0:    code = 4'd1;
         4'd1:    code = 4'd4;
         4'd2:    code = 4'd7;
         4'd3:    code = 4'd10;
         4'd4:    code = 4'd2;
         4'd5:    code = 4'd5;
         4'd6:    code = 4'd8;
         4'd7:    code = 4'd0;
         4'd8:    code = 4'd3;
         4'd9:    code = 4'd6;
         4'd10:   code = 4'd9;
         4'd11:   code = 4'd11;
         default: code = 4'd1;
      endcase
      return code;
   endfunction

endpackage

// File: hw/rtl/kcl_scan_decode.sv
module kcl_scan_decode
   import kcl_pkg::*;
(
   input  req_type  scan_in,
   output scan_type scan_out
);

   logic [1:0]        col;
   logic [1:0]        row;
   logic [ROWS_W-1:0] rows;

   // The first column with any row down wins.
   always_comb begin
      if (scan_in.rows_col_a != '0) begin
         col  = 2'd0;
         rows = scan_in.rows_col_a;
      end else if (scan_in.rows_col_b != '0) begin
         col  = 2'd1;
         rows = scan_in.rows_col_b;
      end else begin
         col  = 2'd2;
         rows = scan_in.rows_col_c;
      end
   end

   // Lowest set row; row three when the lower three are clear.
   always_comb begin
      if (rows[0]) begin
         row = 2'd0;
      end else if (rows[1]) begin
         row = 2'd1;
      end else if (rows[2]) begin
         row = 2'd2;
      end else begin
         row = 2'd3;
      end
   end

   assign scan_out.pressed  = |{scan_in.rows_col_a, scan_in.rows_col_b, scan_in.rows_col_c};
   assign scan_out.key_code = key_map({col, row});

endmodule

// File: hw/rtl/kcl_entry_ctrl.sv
`include "keypad_code_lock_core_defines.svh"

module kcl_entry_ctrl
   import kcl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  scan_type         scan,
   input  secret_array_type secret,
   output rsp_type          rsp
);

   logic             wait_release_ff;
   logic             wait_release_in;
   logic [1:0]       keys_held_ff;
   logic [1:0]       keys_held_in;
   logic [KEY_W-1:0] entered_ff [NUM_DIGITS-1];
   logic             take_key;
   logic             last_key;
   logic             match;

   assign take_key = !wait_release_ff && scan.pressed;
   assign last_key = (keys_held_ff == 2'(NUM_DIGITS - 1));

   // The fourth key is compared straight from the scan; the first three
   // come from the entry store.
   always_comb begin
      match = (scan.key_code == secret[NUM_DIGITS-1]);
      for (int i = 0; i < NUM_DIGITS - 1; i++) begin
         if (entered_ff[i] != secret[i]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      wait_release_in = wait_release_ff;
      keys_held_in    = keys_held_ff;
      rsp.key_valid   = 1'b0;
      rsp.key_code    = '0;
      rsp.digit_count = {1'b0, keys_held_ff};
      rsp.entry_done  = 1'b0;
      rsp.code_ok     = 1'b0;
      if (wait_release_ff) begin
         if (!scan.pressed) begin
            wait_release_in = 1'b0;
         end
      end else if (scan.pressed) begin
         wait_release_in = 1'b1;
         keys_held_in    = keys_held_ff + 2'd1;
         rsp.key_valid   = 1'b1;
         rsp.key_code    = scan.key_code;
         rsp.digit_count = {1'b0, keys_held_ff} + 3'd1;
         if (last_key) begin
            rsp.entry_done = 1'b1;
            rsp.code_ok    = match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_release_ff <= 1'b0;
         keys_held_ff    <= '0;
      end else if (step) begin
         wait_release_ff <= wait_release_in;
         keys_held_ff    <= keys_held_in;
      end
   end

   // Only the first three slots are stored; the fourth key never needs keeping.
   always_ff @(posedge clock) begin
      if (step && take_key && !last_key) begin
         entered_ff[keys_held_ff] <= scan.key_code;
      end
   end

   `KCL_ASSERT(a_done_has_four, clock, reset, step && rsp.entry_done |-> rsp.key_valid && rsp.digit_count == 3'(NUM_DIGITS), "entry done without four keys")
   `KCL_ASSERT(a_key_arms_release, clock, reset, step && rsp.key_valid |=> wait_release_ff, "accepted key did not arm release wait")
   `KCL_ASSERT(a_done_restarts, clock, reset, step && rsp.entry_done |=> keys_held_ff == '0, "entry did not restart after fourth key")
   `KCL_ASSERT(a_no_key_while_held, clock, reset, step && wait_release_ff |-> !rsp.key_valid, "key accepted while waiting for release")

endmodule

// File: hw/rtl/keypad_code_lock_core.sv
// Four-digit code lock driven by 3x4 keypad scans. Each req word is one full
// scan (four row bits per column); each accepted word yields exactly one rsp
// word, which reports a newly pressed key, the digit count of the current
// entry and, on the fourth key, whether the entry matched the secret digits.
// A key is taken only once per press: after a key is accepted, scans are
// ignored until one reads zero on every row. Secret digits are written through
// the csr port (index 0 to 3, reset 1, 2, 3, 4) and should only be changed
// while no word is in flight. The edge that accepts a req word loads the input
// register; the word passes through the decode and entry logic into the result
// register once that register is empty or being drained, and rsp_valid rises
// as the result register is loaded. The block takes one word every cycle,
// limited only by rsp_ready; req_ready stays high while the result register
// drains.
`include "keypad_code_lock_core_defines.svh"

module keypad_code_lock_core
   import kcl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_write,
   input  csr_index_type csr_index,
   input  logic [KEY_W-1:0] csr_wdata
);

   // Input register: holds one scan word.
   req_type          req_ff;
   logic             in_valid_ff;
   logic             in_valid_in;

   // Result register.
   rsp_type          rsp_ff;
   logic             out_valid_ff;
   logic             out_valid_in;

   secret_array_type secret_ff;
   scan_type         scan;
   rsp_type          rsp_next;
   logic             advance;
   logic             req_take;

   // A word moves from the input register to the result register when the
   // result register is empty or is being emptied in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   // Secret digit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         secret_ff <= SECRET_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SECRET_DIGIT_0: secret_ff[0] <= csr_wdata;
            CSR_SECRET_DIGIT_1: secret_ff[1] <= csr_wdata;
            CSR_SECRET_DIGIT_2: secret_ff[2] <= csr_wdata;
            CSR_SECRET_DIGIT_3: secret_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   kcl_scan_decode u_scan_decode (
      .scan_in  (req_ff),
      .scan_out (scan)
   );

   // Entry state advances exactly once per word, as it enters the result register.
   kcl_entry_ctrl u_entry_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .scan   (scan),
      .secret (secret_ff),
      .rsp    (rsp_next)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   `KCL_ASSERT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result word changed while stalled")
   `KCL_ASSERT(a_no_overwrite, clock, reset, advance |-> !out_valid_ff || rsp_ready, "result register overwritten before it was taken")
   `KCL_ASSERT(a_ready_when_empty, clock, reset, !in_valid_ff |-> req_ready, "input register empty but not ready")

endmodule
